// ===== design/led_matrix_shadow_command_driver_macros.svh =====
// Assertion helpers, all clocked on clk with rst_n as the disable
`ifndef LED_MATRIX_SHADOW_COMMAND_DRIVER_MACROS_SVH
`define LED_MATRIX_SHADOW_COMMAND_DRIVER_MACROS_SVH

// same-cycle implication
`define LMSCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LMSCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lmscd_pkg.sv =====
`timescale 1ns / 1ps

package lmscd_pkg;

    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 8;
    localparam int LED_NUM_W   = 6;
    localparam int NUM_COLUMNS = 8;
    localparam int COL_W       = $clog2(NUM_COLUMNS);
    localparam int ROW_W       = LED_NUM_W - COL_W;
    localparam int STEP_W      = 4;
    localparam int INTEN_W     = 4;
    localparam int SCAN_W      = 3;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // controller register addresses
    localparam logic [ADDR_W-1:0] CMD_DECODE    = 4'h9;
    localparam logic [ADDR_W-1:0] CMD_INTENSITY = 4'hA;
    localparam logic [ADDR_W-1:0] CMD_SCANLIMIT = 4'hB;
    localparam logic [ADDR_W-1:0] CMD_SHUTDOWN  = 4'hC;
    localparam logic [ADDR_W-1:0] CMD_TEST      = 4'hF;

    localparam logic [INTEN_W-1:0] INTENSITY_RST = 4'd10;
    localparam logic [SCAN_W-1:0]  SCAN_RST      = 3'd7;

    // configuration register index, taken from paddr[2]
    localparam logic REG_INTENSITY = 1'b0;
    localparam logic REG_SCAN      = 1'b1;

    localparam logic FUNC_INIT = 1'b0;

    // microprogram step addresses
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_INIT      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SCAN      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DECODE    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_COL_FIRST = 4'd4;
    localparam logic [STEP_W-1:0] STEP_COL_LAST  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_INTEN     = 4'd12;
    localparam logic [STEP_W-1:0] STEP_SHUTDOWN  = 4'd13;
    localparam logic [STEP_W-1:0] STEP_SET       = 4'd14;

    typedef enum logic [1:0] {
        SEQ_DISPATCH = 2'd0,
        SEQ_NEXT     = 2'd1,
        SEQ_HOME     = 2'd2
    } seq_op_t;

    typedef enum logic {
        ASRC_CONST  = 1'b0,
        ASRC_COLUMN = 1'b1
    } addr_src_t;

    typedef enum logic [2:0] {
        DSRC_ZERO   = 3'd0,
        DSRC_ONE    = 3'd1,
        DSRC_SCAN   = 3'd2,
        DSRC_INTEN  = 3'd3,
        DSRC_SHADOW = 3'd4
    } data_src_t;

    typedef struct packed {
        logic              accept;
        seq_op_t           seq;
        logic              emit;
        logic              last;
        logic              clear;
        addr_src_t         addr_src;
        logic [ADDR_W-1:0] addr_const;
        data_src_t         data_src;
    } ctrl_t;

    function automatic ctrl_t emit_word(input logic [ADDR_W-1:0] addr, input data_src_t dsrc);
        ctrl_t w;
        w            = '0;
        w.seq        = SEQ_NEXT;
        w.emit       = 1'b1;
        w.addr_src   = ASRC_CONST;
        w.addr_const = addr;
        w.data_src   = dsrc;
        return w;
    endfunction

    // control store
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        unique case (step) inside
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.seq    = SEQ_DISPATCH;
            end
            STEP_INIT:
            begin
                w       = emit_word(CMD_TEST, DSRC_ZERO);
                w.clear = 1'b1;
            end
            STEP_SCAN:   w = emit_word(CMD_SCANLIMIT, DSRC_SCAN);
            STEP_DECODE: w = emit_word(CMD_DECODE, DSRC_ZERO);
            [STEP_COL_FIRST:STEP_COL_LAST]:
                w = emit_word(step - (STEP_COL_FIRST - 4'd1), DSRC_ZERO);
            STEP_INTEN:  w = emit_word(CMD_INTENSITY, DSRC_INTEN);
            STEP_SHUTDOWN:
            begin
                w      = emit_word(CMD_SHUTDOWN, DSRC_ONE);
                w.seq  = SEQ_HOME;
                w.last = 1'b1;
            end
            STEP_SET:
            begin
                w          = emit_word('0, DSRC_SHADOW);
                w.seq      = SEQ_HOME;
                w.last     = 1'b1;
                w.addr_src = ASRC_COLUMN;
            end
            default:
            begin
                w.seq = SEQ_HOME;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/lmscd_in_if.sv =====
`timescale 1ns / 1ps

interface lmscd_in_if;
    import lmscd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [LED_NUM_W-1:0] led_num;
    logic                 led_on;

    modport source (output valid, output func, output led_num, output led_on, input ready);
    modport sink (input valid, input func, input led_num, input led_on, output ready);
endinterface

// ===== design/lmscd_out_if.sv =====
`timescale 1ns / 1ps

interface lmscd_out_if;
    import lmscd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] reg_address;
    logic [DATA_W-1:0] reg_data;
    logic              last;

    modport source (output valid, output reg_address, output reg_data, output last, input ready);
    modport sink (input valid, input reg_address, input reg_data, input last, output ready);
endinterface

// ===== design/lmscd_sequencer.sv =====
`timescale 1ns / 1ps

module lmscd_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_func,
    input  logic              out_free,
    output logic              in_ready,
    output lmscd_pkg::ctrl_t  ctrl
);
    import lmscd_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctrl     = ucode_rom(step_reg);
    assign in_ready = ctrl.accept;

    always_comb
    begin
        step_next = step_reg;
        unique case (ctrl.seq)
            SEQ_DISPATCH:
            begin
                if (in_valid)
                begin
                    step_next = (in_func == FUNC_INIT) ? STEP_INIT : STEP_SET;
                end
            end
            SEQ_NEXT:
            begin
                if (out_free)
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            SEQ_HOME:
            begin
                if (out_free || !ctrl.emit)
                begin
                    step_next = STEP_IDLE;
                end
            end
            default: step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end
endmodule

// ===== design/lmscd_datapath.sv =====
`timescale 1ns / 1ps

module lmscd_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lmscd_pkg::ctrl_t            ctrl,
    input  logic                        in_beat,
    input  logic [lmscd_pkg::LED_NUM_W-1:0] in_led_num,
    input  logic                        in_led_on,
    input  logic [lmscd_pkg::INTEN_W-1:0] intensity_level,
    input  logic [lmscd_pkg::SCAN_W-1:0]  scan_limit,
    output logic                        out_free,
    lmscd_out_if.source                 out_ch
);
    import lmscd_pkg::*;

    logic [LED_NUM_W-1:0]   idx_reg;
    logic                   on_reg;
    logic [DATA_W-1:0]      shadow_reg [NUM_COLUMNS];
    logic [DATA_W-1:0]      shadow_next [NUM_COLUMNS];

    logic                   valid_reg;
    logic                   valid_next;
    logic [ADDR_W-1:0]      addr_reg;
    logic [DATA_W-1:0]      data_reg;
    logic                   last_reg;

    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       row;
    logic [DATA_W-1:0]      row_bit;
    logic [DATA_W-1:0]      new_byte;
    logic [ADDR_W-1:0]      addr_mux;
    logic [DATA_W-1:0]      data_mux;
    logic                   fire;

    assign col      = idx_reg[COL_W-1:0];
    assign row      = idx_reg[LED_NUM_W-1:COL_W];
    assign row_bit  = DATA_W'(1) << row;
    assign new_byte = on_reg ? (shadow_reg[col] | row_bit) : (shadow_reg[col] & ~row_bit);

    assign out_free = !valid_reg || out_ch.ready;
    assign fire     = ctrl.emit && out_free;

    always_comb
    begin
        addr_mux = ctrl.addr_const;
        if (ctrl.addr_src == ASRC_COLUMN)
        begin
            addr_mux = ADDR_W'(col) + 4'd1;
        end
    end

    always_comb
    begin
        case (ctrl.data_src)
            DSRC_ONE:    data_mux = DATA_W'(1);
            DSRC_SCAN:   data_mux = DATA_W'(scan_limit);
            DSRC_INTEN:  data_mux = DATA_W'(intensity_level);
            DSRC_SHADOW: data_mux = new_byte;
            default:     data_mux = '0;
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < NUM_COLUMNS; c++)
        begin
            shadow_next[c] = shadow_reg[c];
            if (ctrl.clear)
            begin
                shadow_next[c] = '0;
            end
            else if (fire && ctrl.data_src == DSRC_SHADOW && col == COL_W'(c))
            begin
                shadow_next[c] = new_byte;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int c = 0; c < NUM_COLUMNS; c++)
            begin
                shadow_reg[c] <= '0;
            end
        end
        else
        begin
            valid_reg  <= valid_next;
            shadow_reg <= shadow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            idx_reg <= in_led_num;
            on_reg  <= in_led_on;
        end
        if (fire)
        begin
            addr_reg <= addr_mux;
            data_reg <= data_mux;
            last_reg <= ctrl.last;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.reg_address = addr_reg;
    assign out_ch.reg_data    = data_reg;
    assign out_ch.last        = last_reg;
endmodule

// ===== design/led_matrix_shadow_command_driver.sv =====
`timescale 1ns / 1ps
`include "led_matrix_shadow_command_driver_macros.svh"

// Command-frame source for a serial 8x8 LED matrix controller. func=0 runs
// init: 13 beats (test off, scan limit, no decode, eight column clears,
// intensity, leave shutdown) and clears the column shadow; func=1 sets or
// clears one LED and sends its whole column byte to register column+1 in a
// single beat. last marks the final beat of each item. One item at a time:
// a microprogram emits one beat per cycle through a single output register
// while the output is not stalled.
// APB: intensity_level at 0x0, scan_limit at 0x4 (paddr[2] selects).
module led_matrix_shadow_command_driver (
    input  logic                          clk,
    input  logic                          rst_n,
    lmscd_in_if.sink                      in_ch,
    lmscd_out_if.source                   out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmscd_pkg::APB_AW-1:0]  paddr,
    input  logic [lmscd_pkg::APB_DW-1:0]  pwdata,
    output logic [lmscd_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import lmscd_pkg::*;

    logic [INTEN_W-1:0] intensity_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic               cfg_wr;
    logic               in_beat;
    logic               init_beat;
    logic               set_beat;
    logic               out_free;
    ctrl_t              ctrl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SCAN) ? APB_DW'(scan_reg) : APB_DW'(intensity_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_reg <= INTENSITY_RST;
            scan_reg      <= SCAN_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SCAN)
            begin
                scan_reg <= pwdata[SCAN_W-1:0];
            end
            else
            begin
                intensity_reg <= pwdata[INTEN_W-1:0];
            end
        end
    end

    assign in_beat   = in_ch.valid && in_ch.ready;
    assign init_beat = in_beat && (in_ch.func == FUNC_INIT);
    assign set_beat  = in_beat && (in_ch.func != FUNC_INIT);

    lmscd_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.func),
        .out_free (out_free),
        .in_ready (in_ch.ready),
        .ctrl     (ctrl)
    );

    lmscd_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .in_beat         (in_beat),
        .in_led_num      (in_ch.led_num),
        .in_led_on       (in_ch.led_on),
        .intensity_level (intensity_reg),
        .scan_limit      (scan_reg),
        .out_free        (out_free),
        .out_ch          (out_ch)
    );

    `LMSCD_ASSERT_NXT(a_one_item, in_beat, !in_ch.ready, "accepted while busy")
    `LMSCD_ASSERT_NXT(a_init_clear, init_beat, ctrl.clear, "init without clear")
    `LMSCD_ASSERT_NXT(a_set_emit, set_beat, ctrl.emit && ctrl.data_src == DSRC_SHADOW, "no set")
    `LMSCD_ASSERT_IMP(a_ready_quiet, in_ch.ready, !ctrl.emit, "emit while taking input")
endmodule
